// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Sizes, codes, controller states and node addressing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int POOL_ORDER = 10;
    localparam int OFF_W      = POOL_ORDER;
    localparam int ORD_W      = 5;
    localparam int NB         = POOL_ORDER + 1;
    localparam int WORD_LG    = (NB < 5) ? NB : 5;
    localparam int WW         = 1 << WORD_LG;
    localparam int NWORDS     = 1 << (NB - WORD_LG);
    localparam int WADDR_W    = (NB - WORD_LG) > 0 ? (NB - WORD_LG) : 1;
    localparam int LEN_W      = 11;
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        (POOL_ORDER < LEN_W) ? LEN_W'(1 << POOL_ORDER) : '0;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_READ,
        S_A_CHECK,
        S_SP_READ,
        S_SP_WRITE,
        S_F_CHECK,
        S_M_READ,
        S_M_CHECK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [ORD_W-1:0] order;
    } alloc_rec_t;

    function automatic logic [NB-1:0] base_of(input logic [ORD_W-1:0] o);
        return NB'(1) << (POOL_ORDER - int'(o));
    endfunction

    function automatic logic [WADDR_W-1:0] word_of(input logic [NB-1:0] n);
        return WADDR_W'(n >> WORD_LG);
    endfunction

    function automatic logic [WW-1:0] bit_of(input logic [NB-1:0] n);
        return WW'(1) << n[WORD_LG-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// A bad request goes straight to the response; allocate scans node words and then splits
// level by level; free reads the allocation record and then merges level by level.
// One request at a time: the next is taken only after the result loads into the output
// register (allocate scans up to 68 node words at POOL_ORDER 10); m_ready stalls delay it.
// Reset: a clearing pass over every record address initializes both RAMs; no request
// is taken until it ends.
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator, node-free bitmap and allocation records in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator
    import bba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [10:0] s_req_length,
    input  wire logic [9:0]  s_block_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [9:0]  m_result_offset,
    output logic      [3:0]  m_granted_order,
    output logic      [1:0]  m_status
);

    state_t state_reg, state_next;
    logic [OFF_W-1:0]   cnt_reg, cnt_next;
    logic [ORD_W-1:0]   o_reg, o_next;
    logic [ORD_W-1:0]   k_reg, k_next;
    logic [WADDR_W-1:0] scan_w_reg, scan_w_next;
    logic [NB-1:0]      n_reg, n_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [9:0]         res_off_reg, res_off_next;
    logic [3:0]         res_ord_reg, res_ord_next;
    logic [1:0]         res_st_reg, res_st_next;
    logic               m_valid_reg, m_valid_next;
    logic [9:0]         m_off_reg, m_off_next;
    logic [3:0]         m_ord_reg, m_ord_next;
    logic [1:0]         m_st_reg, m_st_next;

    logic               nd_we, nd_re;
    logic [WADDR_W-1:0] nd_waddr, nd_raddr;
    logic [WW-1:0]      nd_wdata, nd_rdata;
    logic               av_we, av_re;
    logic [OFF_W-1:0]   av_waddr, av_raddr;
    alloc_rec_t         av_wdata, av_rdata;

    bba_ram #(.WIDTH(WW), .ADDR_W(WADDR_W)) u_node_ram (
        .aclk  (aclk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .re    (nd_re),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    bba_ram #(.WIDTH($bits(alloc_rec_t)), .ADDR_W(OFF_W)) u_rec_ram (
        .aclk  (aclk),
        .we    (av_we),
        .waddr (av_waddr),
        .wdata (av_wdata),
        .re    (av_re),
        .raddr (av_raddr),
        .rdata (av_rdata)
    );

    // request decode
    logic [LEN_W-1:0] len_m1;
    logic [3:0]       len_k;
    logic             len_bad;
    logic [31:0]      boff32;
    logic             boff_bad;

    always_comb begin
        len_m1 = s_req_length - LEN_W'(1);
        len_k  = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (len_m1[i]) begin
                len_k = 4'(i + 1);
            end
        end
        if (s_req_length <= LEN_W'(1)) begin
            len_k = '0;
        end
        len_bad = (s_req_length == '0) ||
                  ((POOL_ORDER < LEN_W) && (s_req_length > LEN_LIMIT));
        boff32   = 32'(s_block_offset);
        boff_bad = (boff32 >> POOL_ORDER) != 32'd0;
    end

    // scan of one node word for the current order
    logic [NB-1:0]      cur_base;
    logic [WW-1:0]      scan_mask, scan_hit;
    logic [WORD_LG-1:0] hit_bit;
    logic [NB-1:0]      n_found, idx;
    logic [OFF_W-1:0]   off_found;
    logic [WADDR_W-1:0] last_w;

    always_comb begin
        cur_base = base_of(o_reg);
        last_w   = word_of((cur_base << 1) - NB'(1));
        for (int b = 0; b < WW; b++) begin
            idx          = (NB'(scan_w_reg) << WORD_LG) | NB'(b);
            scan_mask[b] = (idx >> (POOL_ORDER - int'(o_reg))) == NB'(1);
        end
        scan_hit = nd_rdata & scan_mask;
        hit_bit  = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (scan_hit[b]) begin
                hit_bit = WORD_LG'(b);
            end
        end
        n_found   = (NB'(scan_w_reg) << WORD_LG) | NB'(hit_bit);
        off_found = OFF_W'((n_found & ~cur_base) << o_reg);
    end

    logic [31:0]      off32;
    logic [ORD_W-1:0] rec_k;
    logic [NB-1:0]    child, sib;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        o_next       = o_reg;
        k_next       = k_reg;
        scan_w_next  = scan_w_reg;
        n_next       = n_reg;
        off_next     = off_reg;
        res_off_next = res_off_reg;
        res_ord_next = res_ord_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_off_next   = m_off_reg;
        m_ord_next   = m_ord_reg;
        m_st_next    = m_st_reg;
        nd_we        = 1'b0;
        nd_waddr     = word_of(n_reg);
        nd_wdata     = nd_rdata;
        nd_re        = 1'b0;
        nd_raddr     = word_of(n_reg);
        av_we        = 1'b0;
        av_waddr     = off_reg;
        av_wdata     = '{valid: 1'b1, order: k_reg};
        av_re        = 1'b0;
        av_raddr     = OFF_W'(boff32);
        s_ready      = 1'b0;
        off32        = 32'(off_reg);
        rec_k        = (av_rdata.order > ORD_W'(POOL_ORDER)) ?
                       ORD_W'(POOL_ORDER) : av_rdata.order;
        child        = n_reg << 1;
        sib          = n_reg ^ NB'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                av_we    = 1'b1;
                av_waddr = cnt_reg;
                av_wdata = '0;
                nd_we    = 32'(cnt_reg) < NWORDS;
                nd_waddr = WADDR_W'(cnt_reg);
                nd_wdata = (cnt_reg == '0) ? WW'(2) : '0;
                cnt_next = cnt_reg + OFF_W'(1);
                if (&cnt_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_ALLOC) begin
                        if (len_bad) begin
                            res_off_next = '0;
                            res_ord_next = '0;
                            res_st_next  = ST_BAD;
                            state_next   = S_RESP;
                        end else begin
                            o_next      = ORD_W'(len_k);
                            k_next      = ORD_W'(len_k);
                            scan_w_next = word_of(base_of(ORD_W'(len_k)));
                            state_next  = S_A_READ;
                        end
                    end else begin
                        if (boff_bad) begin
                            res_off_next = '0;
                            res_ord_next = '0;
                            res_st_next  = ST_BAD;
                            state_next   = S_RESP;
                        end else begin
                            av_re      = 1'b1;
                            off_next   = OFF_W'(boff32);
                            state_next = S_F_CHECK;
                        end
                    end
                end
            end
            S_A_READ: begin
                nd_re      = 1'b1;
                nd_raddr   = scan_w_reg;
                state_next = S_A_CHECK;
            end
            S_A_CHECK: begin
                if (scan_hit != '0) begin
                    nd_we    = 1'b1;
                    nd_waddr = word_of(n_found);
                    nd_wdata = nd_rdata & ~bit_of(n_found);
                    n_next   = n_found;
                    off_next = off_found;
                    if (o_reg == k_reg) begin
                        av_we        = 1'b1;
                        av_waddr     = off_found;
                        res_off_next = 10'(32'(off_found));
                        res_ord_next = 4'(k_reg);
                        res_st_next  = ST_OK;
                        state_next   = S_RESP;
                    end else begin
                        state_next = S_SP_READ;
                    end
                end else if (scan_w_reg == last_w) begin
                    if (o_reg == ORD_W'(POOL_ORDER)) begin
                        res_off_next = '0;
                        res_ord_next = '0;
                        res_st_next  = ST_FULL;
                        state_next   = S_RESP;
                    end else begin
                        o_next      = o_reg + ORD_W'(1);
                        scan_w_next = word_of(base_of(o_reg + ORD_W'(1)));
                        state_next  = S_A_READ;
                    end
                end else begin
                    scan_w_next = scan_w_reg + WADDR_W'(1);
                    state_next  = S_A_READ;
                end
            end
            S_SP_READ: begin
                nd_re      = 1'b1;
                nd_raddr   = word_of(child | NB'(1));
                n_next     = child;
                o_next     = o_reg - ORD_W'(1);
                state_next = S_SP_WRITE;
            end
            S_SP_WRITE: begin
                nd_we    = 1'b1;
                nd_waddr = word_of(n_reg | NB'(1));
                nd_wdata = nd_rdata | bit_of(n_reg | NB'(1));
                if (o_reg == k_reg) begin
                    av_we        = 1'b1;
                    res_off_next = 10'(off32);
                    res_ord_next = 4'(k_reg);
                    res_st_next  = ST_OK;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_SP_READ;
                end
            end
            S_F_CHECK: begin
                if (!av_rdata.valid) begin
                    res_off_next = '0;
                    res_ord_next = '0;
                    res_st_next  = ST_BAD;
                    state_next   = S_RESP;
                end else begin
                    av_we      = 1'b1;
                    av_wdata   = '0;
                    k_next     = rec_k;
                    n_next     = base_of(rec_k) | (NB'(off_reg) >> rec_k);
                    state_next = S_M_READ;
                end
            end
            S_M_READ: begin
                nd_re      = 1'b1;
                nd_raddr   = word_of(n_reg);
                state_next = S_M_CHECK;
            end
            S_M_CHECK: begin
                nd_we = 1'b1;
                if ((n_reg != NB'(1)) && ((nd_rdata & bit_of(sib)) != '0)) begin
                    nd_wdata   = nd_rdata & ~bit_of(sib);
                    n_next     = n_reg >> 1;
                    state_next = S_M_READ;
                end else begin
                    nd_wdata     = nd_rdata | bit_of(n_reg);
                    res_off_next = '0;
                    res_ord_next = 4'(k_reg);
                    res_st_next  = ST_OK;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_off_next   = res_off_reg;
                    m_ord_next   = res_ord_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg       <= o_next;
        k_reg       <= k_next;
        scan_w_reg  <= scan_w_next;
        n_reg       <= n_next;
        off_reg     <= off_next;
        res_off_reg <= res_off_next;
        res_ord_reg <= res_ord_next;
        res_st_reg  <= res_st_next;
        m_off_reg   <= m_off_next;
        m_ord_reg   <= m_ord_next;
        m_st_reg    <= m_st_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_offset = m_off_reg;
    assign m_granted_order = m_ord_reg;
    assign m_status        = m_st_reg;

endmodule

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [1 << ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== test/buddy_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests through the request channel, predicts each
// response with a behavioral buddy tree and compares every response transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = 1 << POOL_ORDER;

    typedef struct packed {
        logic [9:0] offset;
        logic [3:0] order;
        logic [1:0] status;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_ALLOC;
    logic [10:0] s_req_length = '0;
    logic [9:0]  s_block_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_result_offset;
    logic [3:0]  m_granted_order;
    logic [1:0]  m_status;

    bit          tree_free [1:2*UNITS-1];
    bit          owned [0:UNITS-1];
    int          owned_order [0:UNITS-1];
    grant_t      pending_grants[$];
    int          live_offsets[$];
    int          errors = 0;
    bit          allow_idle = 1'b1;
    int          stall_left = 0;

    buddy_block_allocator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic grant_t predict_alloc(input int len);
        grant_t g;
        int k, o, i, n, cur;
        g = '{offset: '0, order: '0, status: ST_BAD};
        if (len == 0 || len > UNITS) return g;
        k = 0;
        while ((1 << k) < len) k++;
        for (o = k; o <= POOL_ORDER; o++) begin
            for (i = 0; i < (1 << (POOL_ORDER - o)); i++) begin
                n = (1 << (POOL_ORDER - o)) + i;
                if (tree_free[n]) begin
                    tree_free[n] = 1'b0;
                    cur = o;
                    while (cur > k) begin
                        cur--;
                        n = n << 1;
                        tree_free[n | 1] = 1'b1;
                    end
                    owned[i << o] = 1'b1;
                    owned_order[i << o] = k;
                    live_offsets = {live_offsets, i << o};
                    return '{offset: 10'(i << o), order: 4'(k), status: ST_OK};
                end
            end
        end
        g.status = ST_FULL;
        return g;
    endfunction

    function automatic grant_t predict_free(input int off);
        int k, n, idx;
        if (!owned[off]) return '{offset: '0, order: '0, status: ST_BAD};
        k = owned_order[off];
        owned[off] = 1'b0;
        for (idx = 0; idx < live_offsets.size(); idx++) begin
            if (live_offsets[idx] == off) begin
                live_offsets.delete(idx);
                break;
            end
        end
        n = (1 << (POOL_ORDER - k)) + (off >> k);
        while (n > 1 && tree_free[n ^ 1]) begin
            tree_free[n ^ 1] = 1'b0;
            n = n >> 1;
        end
        tree_free[n] = 1'b1;
        return '{offset: '0, order: 4'(k), status: ST_OK};
    endfunction

    task automatic send_request(input logic kind, input int len, input int off);
        int gap;
        grant_t want;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_req_length   <= 11'(len);
        s_block_offset <= 10'(off);
        do @(posedge aclk); while (!s_ready);
        if (kind == REQ_ALLOC) want = predict_alloc(len);
        else want = predict_free(off);
        pending_grants = {pending_grants, want};
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || !allow_idle) begin
            stall_left = 0;
            m_ready <= aresetn;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected response off=%0d ord=%0d st=%0d", $time,
                         m_result_offset, m_granted_order, m_status);
            end else begin
                want = pending_grants.pop_front();
                if (m_result_offset !== want.offset || m_granted_order !== want.order
                    || m_status !== want.status) begin
                    errors++;
                    $display("%0t: expected off=%0d ord=%0d st=%0d, got off=%0d ord=%0d st=%0d",
                             $time, want.offset, want.order, want.status,
                             m_result_offset, m_granted_order, m_status);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 1025, 0);
        send_request(REQ_ALLOC, 2047, 1023);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 0, 1023);
        send_request(REQ_ALLOC, 1024, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 1024, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_ALLOC, 3, 0);
        send_request(REQ_ALLOC, 5, 0);
        send_request(REQ_ALLOC, 512, 0);
        send_request(REQ_ALLOC, 512, 0);
        send_request(REQ_FREE, 0, 1);
        send_request(REQ_FREE, 0, 4);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 512);
        send_request(REQ_ALLOC, 1000, 0);
        send_request(REQ_FREE, 2047, 0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int r, len;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(1, 1 << $urandom_range(0, 7));
                send_request(REQ_ALLOC, len, $urandom_range(0, 1023));
            end else if (r < 90 && live_offsets.size() != 0) begin
                send_request(REQ_FREE, $urandom_range(0, 2047),
                             live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            end else begin
                send_request(REQ_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end
        end
    endtask

    initial begin
        for (int n = 1; n < 2 * UNITS; n++) tree_free[n] = (n == 1);
        for (int a = 0; a < UNITS; a++) begin
            owned[a] = 1'b0;
            owned_order[a] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(600);
        wait_drained();
        allow_idle = 1'b0;
        test_random(200);
        wait_drained();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
